[hdl/plt_pkg.sv]
// ----------------------------------------------------------------------------
// plt_pkg
// shared types, field widths and codes of the point label table
// ----------------------------------------------------------------------------
package plt_pkg;

  localparam int OPC_W   = 4;
  localparam int POINT_W = 31;
  localparam int VALUE_W = 32;
  localparam int CNT_W   = 11;
  localparam int STAT_W  = 3;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  typedef enum logic [OPC_W-1:0] {
    OP_SET    = 4'd0,
    OP_CLEAR  = 4'd1,
    OP_CLRSTR = 4'd2,
    OP_GET    = 4'd3,
    OP_HAS    = 4'd4,
    OP_SIZE   = 4'd5,
    OP_NUMV   = 4'd6,
    OP_BUILD  = 4'd7,
    OP_DROP   = 4'd8,
    OP_FILTER = 4'd9
  } op_t;

  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOIDX = 3'd3;
  localparam logic [STAT_W-1:0] ST_BIG   = 3'd4;

  // register index taken from paddr bit 2
  localparam logic REG_RSTART = 1'b0;
  localparam logic REG_REND   = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_FIND, S_DISP, S_BSI, S_BS, S_BSCMP, S_BSCHK, S_POST, S_GV,
    S_INSRD, S_INSWR, S_INSPUT, S_CSRD, S_CSBW, S_MVRD, S_MVWR, S_MVFIN,
    S_HAS, S_HASRD, S_BLD, S_BCLR, S_BPRD, S_BPCHK, S_FSTR, S_FRD, S_FWR,
    S_DONE
  } state_t;

endpackage

[hdl/plt_if.sv]
// ----------------------------------------------------------------------------
// plt_if
// valid/ready channels for operation and result beats
// ----------------------------------------------------------------------------
interface plt_in_if;
  logic                                valid;
  logic                                ready;
  logic [plt_pkg::OPC_W-1:0]           opcode;
  logic [plt_pkg::POINT_W-1:0]         point;
  logic signed [plt_pkg::VALUE_W-1:0]  value;
  modport source (output valid, opcode, point, value, input ready);
  modport sink   (input valid, opcode, point, value, output ready);
endinterface

interface plt_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [plt_pkg::VALUE_W-1:0]  found_value;
  logic                                is_present;
  logic [plt_pkg::CNT_W-1:0]           count;
  logic [plt_pkg::STAT_W-1:0]          status;
  modport source (output valid, found_value, is_present, count, status, input ready);
  modport sink   (input valid, found_value, is_present, count, status, output ready);
endinterface

[hdl/plt_ram.sv]
// ----------------------------------------------------------------------------
// plt_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module plt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/point_label_table.sv]
// ----------------------------------------------------------------------------
// point_label_table
// maps points to label values; sorted strata packed in one point store,
// optional presence bitmap over a configured point range
// ----------------------------------------------------------------------------
// channel   dir  handshake       payload
// in_if     in   valid/ready     opcode, point, value
// out_if    out  valid/ready     found_value, is_present, count, status
// cfg_*     in   apb, pready=1   range_start @0, range_end @4
//
// one operation at a time; a lookup step reads the point store, then compares
// set/clear shift point store entries, read then write (one ram port each way)
// build clears range bits, marks stored points; filter compacts, then builds
// no clearing pass after reset: build clears the bitmap before use
// a result waits in the output register while the next beat is taken
// ----------------------------------------------------------------------------
module point_label_table #(
  parameter int MAX_STRATA = 16,
  parameter int MAX_POINTS = 1024,
  parameter int INDEX_BITS = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  plt_in_if.sink                      in_if,
  plt_out_if.source                   out_if,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [plt_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [plt_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [plt_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import plt_pkg::*;

  localparam int SIW = (MAX_STRATA > 1) ? $clog2(MAX_STRATA) : 1;
  localparam int SW  = $clog2(MAX_STRATA + 1);
  localparam int PAW = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int IAW = $clog2(INDEX_BITS);
  localparam int IW  = $clog2(INDEX_BITS + 1);

  state_t state_r, state_nxt;
  logic [OPC_W-1:0]   op_r, op_nxt;
  logic [POINT_W-1:0] pt_r, pt_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [SW-1:0] v_r, v_nxt, total_r, total_nxt;
  logic fnd_r, fnd_nxt, hit_r, hit_nxt, ivalid_r, ivalid_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, sc_r, sc_nxt, base_r, base_nxt;
  logic [CW-1:0] g_r, g_nxt, q_r, q_nxt, e_r, e_nxt, amt_r, amt_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic [POINT_W-1:0] rstart_r, rend_r;
  logic [VALUE_W-1:0] res_found_r, res_found_nxt;
  logic               res_pres_r, res_pres_nxt;
  logic [CW-1:0]      res_cnt_r, res_cnt_nxt;
  logic [STAT_W-1:0]  res_stat_r, res_stat_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_found_r, out_found_nxt;
  logic               out_pres_r, out_pres_nxt;
  logic [CNT_W-1:0]   out_cnt_r, out_cnt_nxt;
  logic [STAT_W-1:0]  out_stat_r, out_stat_nxt;

  logic [VALUE_W-1:0] val_tab_r [MAX_STRATA];
  logic [VALUE_W-1:0] val_tab_nxt [MAX_STRATA];
  logic [CW-1:0]      cnt_tab_r [MAX_STRATA];
  logic [CW-1:0]      cnt_tab_nxt [MAX_STRATA];
  logic [CW-1:0]      base_tab_r [MAX_STRATA];
  logic [CW-1:0]      base_tab_nxt [MAX_STRATA];

  logic               pm_we;
  logic [PAW-1:0]     pm_waddr, pm_raddr;
  logic [POINT_W-1:0] pm_wdata, pm_rdata;
  logic               bm_we, bm_wdata, bm_rdata;
  logic [IAW-1:0]     bm_waddr, bm_raddr;

  logic [SIW-1:0]     vi;
  logic [CW-1:0]      mid;
  logic [POINT_W-1:0] rlen;
  logic               cfg_wr;

  plt_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POINTS)) u_points (
    .clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
    .raddr(pm_raddr), .rdata(pm_rdata)
  );

  plt_ram #(.WIDTH(1), .DEPTH(INDEX_BITS)) u_bitmap (
    .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .raddr(bm_raddr), .rdata(bm_rdata)
  );

  function automatic logic inr(logic [POINT_W-1:0] p, logic [POINT_W-1:0] s,
                               logic [POINT_W-1:0] e);
    return (p >= s) && (p < e);
  endfunction

  assign vi   = v_r[SIW-1:0];
  assign mid  = lo_r + ((hi_r - lo_r) >> 1);
  assign rlen = (rend_r > rstart_r) ? (rend_r - rstart_r) : '0;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_REND) ? {1'b0, rend_r} : {1'b0, rstart_r};

  assign in_if.ready        = (state_r == S_IDLE);
  assign out_if.valid       = out_valid_r;
  assign out_if.found_value = out_found_r;
  assign out_if.is_present  = out_pres_r;
  assign out_if.count       = out_cnt_r;
  assign out_if.status      = out_stat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      used_r      <= '0;
      ivalid_r    <= 1'b0;
      rstart_r    <= '0;
      rend_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_STRATA; i++) begin
        cnt_tab_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      used_r      <= used_nxt;
      ivalid_r    <= ivalid_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_tab_r   <= cnt_tab_nxt;
      if (cfg_wr) begin
        if (cfg_paddr[2] == REG_REND) begin
          rend_r <= cfg_pwdata[POINT_W-1:0];
        end else begin
          rstart_r <= cfg_pwdata[POINT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    pt_r        <= pt_nxt;
    val_r       <= val_nxt;
    v_r         <= v_nxt;
    fnd_r       <= fnd_nxt;
    hit_r       <= hit_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    sc_r        <= sc_nxt;
    base_r      <= base_nxt;
    g_r         <= g_nxt;
    q_r         <= q_nxt;
    e_r         <= e_nxt;
    amt_r       <= amt_nxt;
    k_r         <= k_nxt;
    res_found_r <= res_found_nxt;
    res_pres_r  <= res_pres_nxt;
    res_cnt_r   <= res_cnt_nxt;
    res_stat_r  <= res_stat_nxt;
    out_found_r <= out_found_nxt;
    out_pres_r  <= out_pres_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_stat_r  <= out_stat_nxt;
    val_tab_r   <= val_tab_nxt;
    base_tab_r  <= base_tab_nxt;
  end

  always_comb begin
    logic [POINT_W-1:0] off_p, off_d;
    off_p = pt_r - rstart_r;
    off_d = pm_rdata - rstart_r;

    state_nxt     = state_r;
    op_nxt        = op_r;
    pt_nxt        = pt_r;
    val_nxt       = val_r;
    v_nxt         = v_r;
    fnd_nxt       = fnd_r;
    hit_nxt       = hit_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    sc_nxt        = sc_r;
    base_nxt      = base_r;
    g_nxt         = g_r;
    q_nxt         = q_r;
    e_nxt         = e_r;
    amt_nxt       = amt_r;
    k_nxt         = k_r;
    total_nxt     = total_r;
    used_nxt      = used_r;
    ivalid_nxt    = ivalid_r;
    res_found_nxt = res_found_r;
    res_pres_nxt  = res_pres_r;
    res_cnt_nxt   = res_cnt_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_found_nxt = out_found_r;
    out_pres_nxt  = out_pres_r;
    out_cnt_nxt   = out_cnt_r;
    out_stat_nxt  = out_stat_r;
    val_tab_nxt   = val_tab_r;
    cnt_tab_nxt   = cnt_tab_r;
    base_tab_nxt  = base_tab_r;
    pm_we    = 1'b0;
    pm_waddr = '0;
    pm_wdata = '0;
    pm_raddr = '0;
    bm_we    = 1'b0;
    bm_waddr = '0;
    bm_wdata = 1'b0;
    bm_raddr = '0;

    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          op_nxt        = in_if.opcode;
          pt_nxt        = in_if.point;
          val_nxt       = in_if.value;
          v_nxt         = '0;
          res_found_nxt = '0;
          res_pres_nxt  = 1'b0;
          res_cnt_nxt   = '0;
          res_stat_nxt  = ST_OK;
          state_nxt     = S_DONE;
          case (in_if.opcode)
            OP_SET, OP_CLEAR, OP_CLRSTR, OP_SIZE: state_nxt = S_FIND;
            OP_GET:    state_nxt = S_GV;
            OP_HAS:    state_nxt = S_HAS;
            OP_NUMV:   res_cnt_nxt = CW'(total_r);
            OP_BUILD:  state_nxt = S_BLD;
            OP_DROP:   ivalid_nxt = 1'b0;
            OP_FILTER: begin
              g_nxt     = '0;
              state_nxt = S_FSTR;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_FIND: begin
        if (v_r == total_r) begin
          fnd_nxt   = 1'b0;
          state_nxt = S_DISP;
        end else if (val_tab_r[vi] == val_r) begin
          fnd_nxt   = 1'b1;
          state_nxt = S_DISP;
        end else begin
          v_nxt = v_r + 1'b1;
        end
      end
      S_DISP: begin
        state_nxt = S_DONE;
        case (op_r)
          OP_SIZE: begin
            if (fnd_r) res_cnt_nxt = cnt_tab_r[vi];
          end
          OP_CLRSTR: begin
            if (fnd_r) begin
              amt_nxt   = cnt_tab_r[vi];
              q_nxt     = base_tab_r[vi];
              e_nxt     = base_tab_r[vi] + cnt_tab_r[vi];
              state_nxt = S_CSRD;
            end
          end
          OP_SET, OP_CLEAR: begin
            if (fnd_r) begin
              state_nxt = S_BSI;
            end else begin
              hit_nxt   = 1'b0;
              lo_nxt    = '0;
              state_nxt = S_POST;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_GV: begin
        if (v_r == total_r) begin
          res_found_nxt = '1;
          state_nxt     = S_DONE;
        end else begin
          state_nxt = S_BSI;
        end
      end
      S_BSI: begin
        lo_nxt    = '0;
        hi_nxt    = cnt_tab_r[vi];
        sc_nxt    = cnt_tab_r[vi];
        base_nxt  = base_tab_r[vi];
        state_nxt = S_BS;
      end
      S_BS: begin
        if (lo_r == hi_r) begin
          if (lo_r < sc_r) begin
            pm_raddr  = PAW'(base_r + lo_r);
            state_nxt = S_BSCHK;
          end else begin
            hit_nxt   = 1'b0;
            state_nxt = S_POST;
          end
        end else begin
          pm_raddr  = PAW'(base_r + mid);
          state_nxt = S_BSCMP;
        end
      end
      S_BSCMP: begin
        if (pm_rdata < pt_r) lo_nxt = mid + 1'b1;
        else hi_nxt = mid;
        state_nxt = S_BS;
      end
      S_BSCHK: begin
        hit_nxt   = (pm_rdata == pt_r);
        state_nxt = S_POST;
      end
      S_POST: begin
        state_nxt = S_DONE;
        case (op_r)
          OP_GET: begin
            if (hit_r) begin
              res_found_nxt = val_tab_r[vi];
              res_pres_nxt  = 1'b1;
            end else begin
              v_nxt     = v_r + 1'b1;
              state_nxt = S_GV;
            end
          end
          OP_SET: begin
            if (fnd_r && hit_r) begin
              res_stat_nxt = ST_OK;
            end else if (ivalid_r && !inr(pt_r, rstart_r, rend_r)) begin
              res_stat_nxt = ST_RANGE;
            end else if (used_r >= CW'(MAX_POINTS)) begin
              res_stat_nxt = ST_FULL;
            end else if (!fnd_r && (total_r >= SW'(MAX_STRATA))) begin
              res_stat_nxt = ST_FULL;
            end else begin
              if (fnd_r) begin
                g_nxt = base_r + lo_r;
              end else begin
                val_tab_nxt[total_r[SIW-1:0]]  = val_r;
                base_tab_nxt[total_r[SIW-1:0]] = used_r;
                cnt_tab_nxt[total_r[SIW-1:0]]  = '0;
                total_nxt = total_r + 1'b1;
                v_nxt     = total_r;
                g_nxt     = used_r;
              end
              q_nxt     = used_r;
              state_nxt = S_INSRD;
            end
          end
          OP_CLEAR: begin
            if (fnd_r && hit_r) begin
              amt_nxt   = CW'(1);
              q_nxt     = base_r + lo_r + 1'b1;
              state_nxt = S_MVRD;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_INSRD: begin
        if (q_r == g_r) begin
          state_nxt = S_INSPUT;
        end else begin
          pm_raddr  = PAW'(q_r - 1'b1);
          state_nxt = S_INSWR;
        end
      end
      S_INSWR: begin
        pm_we     = 1'b1;
        pm_waddr  = q_r[PAW-1:0];
        pm_wdata  = pm_rdata;
        q_nxt     = q_r - 1'b1;
        state_nxt = S_INSRD;
      end
      S_INSPUT: begin
        pm_we    = 1'b1;
        pm_waddr = g_r[PAW-1:0];
        pm_wdata = pt_r;
        cnt_tab_nxt[vi] = cnt_tab_r[vi] + 1'b1;
        for (int w = 0; w < MAX_STRATA; w++) begin
          if (SW'(w) > v_r) base_tab_nxt[w] = base_tab_r[w] + 1'b1;
        end
        used_nxt = used_r + 1'b1;
        if (ivalid_r && inr(pt_r, rstart_r, rend_r) && off_p < POINT_W'(INDEX_BITS)) begin
          bm_we    = 1'b1;
          bm_waddr = off_p[IAW-1:0];
          bm_wdata = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_CSRD: begin
        if (q_r == e_r) begin
          state_nxt = S_MVRD;
        end else begin
          pm_raddr  = q_r[PAW-1:0];
          state_nxt = S_CSBW;
        end
      end
      S_CSBW: begin
        if (ivalid_r && inr(pm_rdata, rstart_r, rend_r) && off_d < POINT_W'(INDEX_BITS)) begin
          bm_we    = 1'b1;
          bm_waddr = off_d[IAW-1:0];
          bm_wdata = 1'b0;
        end
        q_nxt     = q_r + 1'b1;
        state_nxt = S_CSRD;
      end
      S_MVRD: begin
        if (q_r == used_r) begin
          state_nxt = S_MVFIN;
        end else begin
          pm_raddr  = q_r[PAW-1:0];
          state_nxt = S_MVWR;
        end
      end
      S_MVWR: begin
        pm_we     = 1'b1;
        pm_waddr  = PAW'(q_r - amt_r);
        pm_wdata  = pm_rdata;
        q_nxt     = q_r + 1'b1;
        state_nxt = S_MVRD;
      end
      S_MVFIN: begin
        cnt_tab_nxt[vi] = cnt_tab_r[vi] - amt_r;
        for (int w = 0; w < MAX_STRATA; w++) begin
          if (SW'(w) > v_r) base_tab_nxt[w] = base_tab_r[w] - amt_r;
        end
        used_nxt = used_r - amt_r;
        if ((op_r == OP_CLEAR) && ivalid_r && inr(pt_r, rstart_r, rend_r)
            && off_p < POINT_W'(INDEX_BITS)) begin
          bm_we    = 1'b1;
          bm_waddr = off_p[IAW-1:0];
          bm_wdata = 1'b0;
        end
        state_nxt = S_DONE;
      end
      S_HAS: begin
        if (!ivalid_r) begin
          res_stat_nxt = ST_NOIDX;
          state_nxt    = S_DONE;
        end else if (!inr(pt_r, rstart_r, rend_r) || off_p >= POINT_W'(INDEX_BITS)) begin
          res_stat_nxt = ST_RANGE;
          state_nxt    = S_DONE;
        end else begin
          bm_raddr  = off_p[IAW-1:0];
          state_nxt = S_HASRD;
        end
      end
      S_HASRD: begin
        res_pres_nxt = bm_rdata;
        state_nxt    = S_DONE;
      end
      S_BLD: begin
        ivalid_nxt = 1'b0;
        if (rlen > POINT_W'(INDEX_BITS)) begin
          res_stat_nxt = ST_BIG;
          state_nxt    = S_DONE;
        end else begin
          k_nxt     = '0;
          state_nxt = S_BCLR;
        end
      end
      S_BCLR: begin
        if (k_r == rlen[IW-1:0]) begin
          q_nxt     = '0;
          state_nxt = S_BPRD;
        end else begin
          bm_we    = 1'b1;
          bm_waddr = k_r[IAW-1:0];
          bm_wdata = 1'b0;
          k_nxt    = k_r + 1'b1;
        end
      end
      S_BPRD: begin
        if (q_r == used_r) begin
          ivalid_nxt   = 1'b1;
          res_stat_nxt = ST_OK;
          state_nxt    = S_DONE;
        end else begin
          pm_raddr  = q_r[PAW-1:0];
          state_nxt = S_BPCHK;
        end
      end
      S_BPCHK: begin
        if (!inr(pm_rdata, rstart_r, rend_r)) begin
          res_stat_nxt = ST_RANGE;
          state_nxt    = S_DONE;
        end else begin
          bm_we     = 1'b1;
          bm_waddr  = off_d[IAW-1:0];
          bm_wdata  = 1'b1;
          q_nxt     = q_r + 1'b1;
          state_nxt = S_BPRD;
        end
      end
      S_FSTR: begin
        if (v_r == total_r) begin
          used_nxt  = g_r;
          state_nxt = S_BLD;
        end else begin
          q_nxt     = base_tab_r[vi];
          e_nxt     = base_tab_r[vi] + cnt_tab_r[vi];
          amt_nxt   = g_r;
          state_nxt = S_FRD;
        end
      end
      S_FRD: begin
        if (q_r == e_r) begin
          base_tab_nxt[vi] = amt_r;
          cnt_tab_nxt[vi]  = g_r - amt_r;
          v_nxt            = v_r + 1'b1;
          state_nxt        = S_FSTR;
        end else begin
          pm_raddr  = q_r[PAW-1:0];
          state_nxt = S_FWR;
        end
      end
      S_FWR: begin
        if (inr(pm_rdata, rstart_r, rend_r)) begin
          pm_we    = 1'b1;
          pm_waddr = g_r[PAW-1:0];
          pm_wdata = pm_rdata;
          g_nxt    = g_r + 1'b1;
        end
        q_nxt     = q_r + 1'b1;
        state_nxt = S_FRD;
      end
      S_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_pres_nxt  = res_pres_r;
          out_cnt_nxt   = CNT_W'(res_cnt_r);
          out_stat_nxt  = res_stat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // a register write drops the index
    if (cfg_wr) ivalid_nxt = 1'b0;
  end

  a_used_cap: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(MAX_POINTS)) else $error("point store overfilled");

  a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= SW'(MAX_STRATA)) else $error("stratum count overflow");

  a_index_len: assert property (@(posedge clk) disable iff (!rst_n)
    ivalid_r |-> (rlen <= POINT_W'(INDEX_BITS))) else $error("index valid over long range");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE) else $error("result beat not from done");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> !(state_r == S_IDLE && $past(state_r) != S_DONE
                              && $past(state_r) != S_IDLE))
    else $error("sequencer left work without result");

endmodule

[verif/point_label_table_tb.sv]
// ----------------------------------------------------------------------------
// point_label_table_tb
// drives operation beats into the point label table, predicts every result
// beat from a model of the strata, point store and presence bitmap kept here,
// and compares each result beat field by field under random idling and stalls
// ----------------------------------------------------------------------------
module point_label_table_tb;
  import plt_pkg::*;

  localparam int NSTRATA = 16;
  localparam int NPOINTS = 1024;
  localparam int NBITS   = 4096;

  typedef struct packed {
    logic signed [VALUE_W-1:0] found_value;
    logic                      is_present;
    logic [CNT_W-1:0]          count;
    logic [STAT_W-1:0]         status;
  } label_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [APB_AW-1:0] cfg_paddr = '0;
  logic [APB_DW-1:0] cfg_pwdata = '0;
  logic [APB_DW-1:0] cfg_prdata;
  logic cfg_pready;

  plt_in_if  in_if ();
  plt_out_if out_if ();

  point_label_table dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the table
  logic [VALUE_W-1:0] sh_val  [NSTRATA];
  int unsigned        sh_cnt  [NSTRATA];
  int unsigned        sh_base [NSTRATA];
  logic [POINT_W-1:0] sh_pts  [NPOINTS];
  bit                 sh_bits [NBITS];
  int unsigned        sh_total = 0;
  bit                 sh_idx = 0;
  logic [POINT_W-1:0] sh_rs = '0, sh_re = '0;

  label_res_t expected_results[$];
  int errors = 0, beats_in = 0, beats_out = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  int cyc = 0, hold_until = 0;
  logic [VALUE_W-1:0] label_pool [18];

  function automatic int unsigned used_points();
    return sh_total == 0 ? 0 : sh_base[sh_total-1] + sh_cnt[sh_total-1];
  endfunction

  function automatic int unsigned find_label(logic [VALUE_W-1:0] v);
    int unsigned k;
    for (k = 0; k < sh_total; k++) if (sh_val[k] == v) break;
    return k;
  endfunction

  function automatic bit in_window(logic [POINT_W-1:0] p);
    return p >= sh_rs && p < sh_re;
  endfunction

  function automatic bit stratum_holds(int unsigned k, logic [POINT_W-1:0] p,
                                       output int unsigned pos);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = sh_cnt[k];
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (sh_pts[sh_base[k] + mid] < p) lo = mid + 1; else hi = mid;
    end
    pos = lo;
    return lo < sh_cnt[k] && sh_pts[sh_base[k] + lo] == p;
  endfunction

  function automatic void mark_bit(logic [POINT_W-1:0] p, bit b);
    if (sh_idx && in_window(p) && (p - sh_rs) < NBITS) sh_bits[p - sh_rs] = b;
  endfunction

  function automatic logic [STAT_W-1:0] rebuild_bitmap();
    int unsigned len, n, i;
    len = sh_re > sh_rs ? sh_re - sh_rs : 0;
    n = used_points();
    sh_idx = 0;
    if (len > NBITS) return ST_BIG;
    foreach (sh_bits[j]) sh_bits[j] = 0;
    for (i = 0; i < n; i++) begin
      if (!in_window(sh_pts[i])) return ST_RANGE;
      sh_bits[sh_pts[i] - sh_rs] = 1;
    end
    sh_idx = 1;
    return ST_OK;
  endfunction

  function automatic logic [STAT_W-1:0] insert_point(logic [POINT_W-1:0] p,
                                                     logic [VALUE_W-1:0] v);
    int unsigned k, pos, n, g, i;
    k = find_label(v);
    if (k < sh_total && stratum_holds(k, p, pos)) return ST_OK;
    if (sh_idx && !in_window(p)) return ST_RANGE;
    n = used_points();
    if (n >= NPOINTS) return ST_FULL;
    if (k >= sh_total) begin
      if (sh_total >= NSTRATA) return ST_FULL;
      sh_val[k] = v;
      sh_base[k] = n;
      sh_cnt[k] = 0;
      sh_total++;
      pos = 0;
    end
    g = sh_base[k] + pos;
    for (i = n; i > g; i--) sh_pts[i] = sh_pts[i-1];
    sh_pts[g] = p;
    sh_cnt[k]++;
    for (i = k + 1; i < sh_total; i++) sh_base[i]++;
    mark_bit(p, 1);
    return ST_OK;
  endfunction

  function automatic void remove_point(logic [POINT_W-1:0] p, logic [VALUE_W-1:0] v);
    int unsigned k, pos, n, g, i;
    k = find_label(v);
    if (k >= sh_total || !stratum_holds(k, p, pos)) return;
    n = used_points();
    g = sh_base[k] + pos;
    for (i = g; i + 1 < n; i++) sh_pts[i] = sh_pts[i+1];
    sh_cnt[k]--;
    for (i = k + 1; i < sh_total; i++) sh_base[i]--;
    mark_bit(p, 0);
  endfunction

  function automatic void empty_stratum(logic [VALUE_W-1:0] v);
    int unsigned k, b, c, n, i;
    k = find_label(v);
    if (k >= sh_total) return;
    b = sh_base[k];
    c = sh_cnt[k];
    n = used_points();
    for (i = 0; i < c; i++) mark_bit(sh_pts[b + i], 0);
    for (i = b; i + c < n; i++) sh_pts[i] = sh_pts[i + c];
    sh_cnt[k] = 0;
    for (i = k + 1; i < sh_total; i++) sh_base[i] -= c;
  endfunction

  function automatic logic [STAT_W-1:0] filter_points();
    int unsigned k, w, b, c, q, nb;
    w = 0;
    for (k = 0; k < sh_total; k++) begin
      b = sh_base[k];
      c = sh_cnt[k];
      nb = w;
      for (q = b; q < b + c; q++) if (in_window(sh_pts[q])) sh_pts[w++] = sh_pts[q];
      sh_base[k] = nb;
      sh_cnt[k] = w - nb;
    end
    return rebuild_bitmap();
  endfunction

  function automatic label_res_t predict_label_op(logic [OPC_W-1:0] op,
                                                  logic [POINT_W-1:0] p,
                                                  logic [VALUE_W-1:0] v);
    label_res_t r;
    int unsigned k, pos;
    r = '0;
    case (op)
      OP_SET:    r.status = insert_point(p, v);
      OP_CLEAR:  remove_point(p, v);
      OP_CLRSTR: empty_stratum(v);
      OP_GET: begin
        r.found_value = -1;
        for (k = 0; k < sh_total; k++)
          if (stratum_holds(k, p, pos)) begin
            r.found_value = sh_val[k];
            r.is_present = 1'b1;
            break;
          end
      end
      OP_HAS: begin
        if (!sh_idx) r.status = ST_NOIDX;
        else if (!in_window(p) || (p - sh_rs) >= NBITS) r.status = ST_RANGE;
        else r.is_present = sh_bits[p - sh_rs];
      end
      OP_SIZE: begin
        k = find_label(v);
        if (k < sh_total) r.count = sh_cnt[k];
      end
      OP_NUMV:   r.count = sh_total;
      OP_BUILD:  r.status = rebuild_bitmap();
      OP_DROP:   sh_idx = 0;
      OP_FILTER: r.status = filter_points();
      default: ;
    endcase
    return r;
  endfunction

  // receiver, with an optional long hold-off
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst_n || cyc < hold_until) out_if.ready <= 1'b0;
    else out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    label_res_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      beats_out++;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_if.found_value !== e.found_value) begin
          $error("found_value expected %0d got %0d", e.found_value, out_if.found_value);
          errors++;
        end
        if (out_if.is_present !== e.is_present) begin
          $error("is_present expected %0d got %0d", e.is_present, out_if.is_present);
          errors++;
        end
        if (out_if.count !== e.count) begin
          $error("count expected %0d got %0d", e.count, out_if.count);
          errors++;
        end
        if (out_if.status !== e.status) begin
          $error("status expected %0d got %0d", e.status, out_if.status);
          errors++;
        end
      end
    end
  end

  task automatic send_op(logic [OPC_W-1:0] op, logic [POINT_W-1:0] p,
                         logic [VALUE_W-1:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.opcode <= op;
    in_if.point  <= p;
    in_if.value  <= v;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    beats_in++;
    expected_results.push_back(predict_label_op(op, p, v));
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0 && guard < 2000000) begin
      @(posedge clk);
      guard++;
    end
    if (expected_results.size() != 0) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [APB_DW-1:0] d);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= d;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_RSTART) sh_rs = d[POINT_W-1:0]; else sh_re = d[POINT_W-1:0];
    sh_idx = 0;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata[POINT_W-1:0] !== d[POINT_W-1:0]) begin
      $error("prdata expected %0h got %0h", d[POINT_W-1:0], cfg_prdata[POINT_W-1:0]);
      errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_window(logic [POINT_W-1:0] s, logic [POINT_W-1:0] e);
    drain();
    cfg_write(REG_RSTART, {1'($urandom_range(1)), s});
    cfg_write(REG_REND, {1'($urandom_range(1)), e});
  endtask

  task automatic test_point_store_full();
    for (int i = 0; i <= NPOINTS; i++) send_op(OP_SET, POINT_W'(i), 32'd7);
    send_op(OP_SET, 31'h7FFF_FFFF, 32'd99);
    send_op(OP_SIZE, 0, 32'd7);
    send_op(OP_CLRSTR, 0, 32'd7);
    send_op(OP_SIZE, 0, 32'd7);
  endtask

  task automatic test_strata_full();
    label_pool[0] = 32'd7;
    label_pool[1] = 32'd0;
    label_pool[2] = 32'hFFFF_FFFF;
    label_pool[3] = 32'h7FFF_FFFF;
    label_pool[4] = 32'h8000_0000;
    for (int i = 5; i < 18; i++) label_pool[i] = $urandom() ^ (i << 4);
    for (int i = 0; i < 17; i++) send_op(OP_SET, 31'd3, label_pool[i]);
    send_op(OP_NUMV, 0, 0);
    send_op(OP_SIZE, 0, label_pool[17]);
  endtask

  task automatic test_directed();
    set_window(0, 16);
    send_op(OP_GET, 31'd9, 0);
    send_op(OP_SET, 31'd5, 32'h7FFF_FFFF);
    send_op(OP_SET, 31'd5, 32'h7FFF_FFFF);
    send_op(OP_SET, 31'h7FFF_FFFF, 32'h8000_0000);
    send_op(OP_GET, 31'h7FFF_FFFF, 0);
    send_op(OP_HAS, 31'd5, 0);
    send_op(OP_BUILD, 0, 0);
    send_op(OP_CLEAR, 31'd6, 32'h7FFF_FFFF);
    send_op(OP_CLRSTR, 0, 32'h1234_5678);
    send_op(OP_FILTER, 0, 0);
    send_op(OP_HAS, 31'd5, 0);
    send_op(OP_HAS, 31'd16, 0);
    send_op(OP_SET, 31'd40, 32'hFFFF_FFFF);
    send_op(OP_CLEAR, 31'd5, 32'h7FFF_FFFF);
    send_op(OP_HAS, 31'd5, 0);
    send_op(OP_DROP, 0, 0);
    send_op(OP_HAS, 31'd5, 0);
    send_op(4'd10, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_op(4'd15, 31'd1, 32'd1);
    set_window(31'd9, 31'd2);
    send_op(OP_BUILD, 0, 0);
    set_window(0, NBITS + 1);
    send_op(OP_BUILD, 0, 0);
    send_op(OP_FILTER, 0, 0);
    set_window(0, NBITS);
    send_op(OP_BUILD, 0, 0);
    send_op(OP_HAS, NBITS - 1, 0);
  endtask

  task automatic pick_window();
    int unsigned kind, len;
    logic [POINT_W-1:0] s;
    kind = $urandom_range(9);
    len  = $urandom_range(40, 200);
    s    = POINT_W'($urandom_range(0, 100000));
    if (kind == 0) s = POINT_W'(31'h7FFF_FFFF - len);
    if (kind == 1) len = NBITS;
    if (kind == 2) s = 31'h7FFF_FFFF;
    if (kind == 2) len = 0;
    set_window(s, POINT_W'(s + len));
  endtask

  task automatic test_random(int n, int idle, int stall);
    int unsigned w, len;
    logic [OPC_W-1:0] op;
    logic [POINT_W-1:0] p;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if (i % 120 == 0) pick_window();
      len = sh_re > sh_rs ? sh_re - sh_rs : 0;
      w = $urandom_range(99);
      if (w < 35) op = OP_SET;
      else if (w < 50) op = OP_CLEAR;
      else if (w < 64) op = OP_GET;
      else if (w < 75) op = OP_HAS;
      else if (w < 80) op = OP_SIZE;
      else if (w < 83) op = OP_NUMV;
      else if (w < 88) op = OP_CLRSTR;
      else if (w < 92) op = OP_BUILD;
      else if (w < 94) op = OP_DROP;
      else if (w < 97) op = OP_FILTER;
      else op = 4'($urandom_range(10, 15));
      if ($urandom_range(3) == 0) p = POINT_W'($urandom());
      else p = POINT_W'(sh_rs + $urandom_range(0, len + 3) - 2);
      send_op(op, p, label_pool[$urandom_range(17)]);
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_until = cyc + 400;
    for (int i = 0; i < 20; i++) send_op(OP_GET, POINT_W'($urandom_range(0, 50)), 0);
    drain();
    for (int i = 0; i < 10; i++) send_op(OP_NUMV, 0, 0);
  endtask

  initial begin
    in_if.valid  = 1'b0;
    in_if.opcode = '0;
    in_if.point  = '0;
    in_if.value  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_point_store_full();
    test_strata_full();
    test_directed();
    test_backpressure();
    test_random(100, 0, 0);
    test_random(100, 68, 0);
    test_random(100, 0, 68);
    test_random(100, 22, 22);
    drain();
    repeat (50) @(posedge clk);
    $display("covered set/clear/lookup/index/filter ops, full tables and window extremes");
    $display("%0d operation beats sent, %0d result beats checked", beats_in, beats_out);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #400000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
